FILE: rtl/bgp_session_fsm_core_macros.svh
// ----------------------------------------------------------------------------
// BGP session FSM core - assertion macros
// Shared concurrent assertion wrappers; empty bodies when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef BGP_SESSION_FSM_CORE_MACROS_SVH
`define BGP_SESSION_FSM_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define BSF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bsf assertion failed");
`define BSF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bsf assertion failed");
`else
`define BSF_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BSF_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/bsf_pkg.sv
// ----------------------------------------------------------------------------
// BGP session FSM package
// State, event, timer, message and notification codes; queue and result types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bsf_pkg;

  typedef logic [2:0] state_t;
  typedef logic [3:0] ev_t;
  typedef logic [3:0] cls_t;
  typedef logic [1:0] tmr_t;
  typedef logic [1:0] msg_t;
  typedef logic [2:0] note_t;

  localparam state_t ST_IDLE        = 3'd0;
  localparam state_t ST_CONNECT     = 3'd1;
  localparam state_t ST_ACTIVE      = 3'd2;
  localparam state_t ST_OPENSENT    = 3'd3;
  localparam state_t ST_OPENCONFIRM = 3'd4;
  localparam state_t ST_ESTABLISHED = 3'd5;

  localparam tmr_t TMR_NONE    = 2'd0;
  localparam tmr_t TMR_RESTART = 2'd1;
  localparam tmr_t TMR_ZERO    = 2'd2;
  localparam tmr_t TMR_LARGE   = 2'd3;

  localparam msg_t MSG_NONE      = 2'd0;
  localparam msg_t MSG_OPEN      = 2'd1;
  localparam msg_t MSG_KEEPALIVE = 2'd2;
  localparam msg_t MSG_NOTIFY    = 2'd3;

  localparam ev_t EV_START        = 4'd0;
  localparam ev_t EV_RETRY        = 4'd1;
  localparam ev_t EV_OPEN         = 4'd2;
  localparam ev_t EV_KEEPALIVE    = 4'd3;
  localparam ev_t EV_UPDATE       = 4'd4;
  localparam ev_t EV_KA_TIMER     = 4'd5;
  localparam ev_t EV_HOLD         = 4'd6;
  localparam ev_t EV_NOTIF        = 4'd7;
  localparam ev_t EV_NOTIF_VER    = 4'd8;
  localparam ev_t EV_HEADER_ERR   = 4'd9;
  localparam ev_t EV_OPEN_ERR     = 4'd10;
  localparam ev_t EV_UNSUP_CAP    = 4'd11;
  localparam ev_t EV_UPDATE_ERR   = 4'd12;
  localparam ev_t EV_FSM_ERR      = 4'd13;
  localparam ev_t REASON_TCP_FAIL = 4'd14;

  localparam note_t NOTE_NONE   = 3'd0;
  localparam note_t NOTE_HEADER = 3'd1;
  localparam note_t NOTE_UPDATE = 3'd3;
  localparam note_t NOTE_HOLD   = 3'd4;
  localparam note_t NOTE_FSM    = 3'd5;

  // event classes seen by the back end
  localparam cls_t CLS_RETRY       = 4'd0;
  localparam cls_t CLS_OPEN        = 4'd1;
  localparam cls_t CLS_KEEPALIVE   = 4'd2;
  localparam cls_t CLS_UPDATE      = 4'd3;
  localparam cls_t CLS_KA_TIMER    = 4'd4;
  localparam cls_t CLS_NOTIF       = 4'd5;
  localparam cls_t CLS_OPEN_REJECT = 4'd6;
  localparam cls_t CLS_ERROR       = 4'd7;

  typedef struct packed {
    cls_t  cls;
    ev_t   reason;
    logic  conn;
    logic  fail;
    note_t note;
    note_t note_est;
  } evt_t;

  typedef struct packed {
    state_t next_state;
    tmr_t   retry_timer_action;
    tmr_t   keepalive_timer_action;
    tmr_t   hold_timer_action;
    msg_t   send_message;
    note_t  notify_error;
    logic   clear_retry_count;
    logic   start_connection;
    logic   finish_init;
    logic   reset_request;
    ev_t    reset_reason;
    logic   unexpected_event;
  } res_t;

endpackage

FILE: rtl/bsf_in_if.sv
// ----------------------------------------------------------------------------
// BGP session FSM event channel
// Valid/ready channel carrying one session event per transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bsf_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] event_code;
  logic       connection_ok;
  logic       send_fails;

  modport source (output valid, output event_code, output connection_ok,
                  output send_fails, input ready);
  modport sink   (input valid, input event_code, input connection_ok,
                  input send_fails, output ready);
endinterface

FILE: rtl/bsf_out_if.sv
// ----------------------------------------------------------------------------
// BGP session FSM result channel
// Valid/ready channel carrying one session action set per transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bsf_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] next_state;
  logic [1:0] retry_timer_action;
  logic [1:0] keepalive_timer_action;
  logic [1:0] hold_timer_action;
  logic [1:0] send_message;
  logic [2:0] notify_error;
  logic       clear_retry_count;
  logic       start_connection;
  logic       finish_init;
  logic       reset_request;
  logic [3:0] reset_reason;
  logic       unexpected_event;

  modport source (output valid, output next_state, output retry_timer_action,
                  output keepalive_timer_action, output hold_timer_action,
                  output send_message, output notify_error,
                  output clear_retry_count, output start_connection,
                  output finish_init, output reset_request,
                  output reset_reason, output unexpected_event, input ready);
  modport sink   (input valid, input next_state, input retry_timer_action,
                  input keepalive_timer_action, input hold_timer_action,
                  input send_message, input notify_error,
                  input clear_retry_count, input start_connection,
                  input finish_init, input reset_request,
                  input reset_reason, input unexpected_event, output ready);
endinterface

FILE: rtl/bgp_session_fsm_core.sv
// ----------------------------------------------------------------------------
// BGP session FSM core
// Per-event BGP session state machine with decoupled classify and execute.
//
//   channel  dir  handshake        transaction
//   in_ch    in   valid / ready    one event: code, connection ok, send fails
//   out_ch   out  valid / ready    one action set: state, timers, message...
//
// One event per cycle sustained while out_ch is not stalled; the queue is written
// at the accepting edge and the event decoded into the output register when popped.
// Throughput is set by the combinational decode on the session state register.
// Synchronous active-low reset returns the session to idle, queue empty.
// in_ch.ready drops only when the event queue holds QUEUE_DEPTH transactions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bgp_session_fsm_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  bsf_in_if.sink    in_ch,
  bsf_out_if.source out_ch
);
  import bsf_pkg::*;

  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_valid;
  evt_t q_wdata;
  evt_t q_rdata;

  bsf_front u_front (
    .in_ch   (in_ch),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_wdata (q_wdata)
  );

  bsf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .full   (q_full),
    .pop    (q_pop),
    .rvalid (q_valid),
    .rdata  (q_rdata)
  );

  bsf_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_rdata (q_rdata),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

FILE: rtl/bsf_front.sv
// ----------------------------------------------------------------------------
// BGP session FSM front end
// Accepts events, saturates unknown codes and classifies them for the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsf_front (
  bsf_in_if.sink        in_ch,
  input  logic          q_full,
  output logic          q_push,
  output bsf_pkg::evt_t q_wdata
);
  import bsf_pkg::*;

  ev_t ev_sat;

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  always_comb begin
    ev_sat = (in_ch.event_code > EV_FSM_ERR) ? EV_FSM_ERR : in_ch.event_code;

    q_wdata        = '0;
    q_wdata.reason = ev_sat;
    q_wdata.conn   = in_ch.connection_ok;
    q_wdata.fail   = in_ch.send_fails;

    unique case (ev_sat)
      EV_RETRY:                   q_wdata.cls = CLS_RETRY;
      EV_OPEN:                    q_wdata.cls = CLS_OPEN;
      EV_KEEPALIVE:               q_wdata.cls = CLS_KEEPALIVE;
      EV_UPDATE:                  q_wdata.cls = CLS_UPDATE;
      EV_KA_TIMER:                q_wdata.cls = CLS_KA_TIMER;
      EV_NOTIF, EV_NOTIF_VER:     q_wdata.cls = CLS_NOTIF;
      EV_OPEN_ERR, EV_UNSUP_CAP:  q_wdata.cls = CLS_OPEN_REJECT;
      default:                    q_wdata.cls = CLS_ERROR;
    endcase

    if (ev_sat == EV_HEADER_ERR) begin
      q_wdata.note = NOTE_HEADER;
    end else if (ev_sat == EV_HOLD) begin
      q_wdata.note = NOTE_HOLD;
    end else begin
      q_wdata.note = NOTE_FSM;
    end

    // update errors are reported as such only once established
    q_wdata.note_est = (ev_sat == EV_UPDATE_ERR) ? NOTE_UPDATE : q_wdata.note;
  end

endmodule

FILE: rtl/bsf_queue.sv
// ----------------------------------------------------------------------------
// BGP session FSM event queue
// Short register FIFO decoupling the classifier from the state machine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bgp_session_fsm_core_macros.svh"

module bsf_queue #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  bsf_pkg::evt_t wdata,
  output logic          full,
  input  logic          pop,
  output logic          rvalid,
  output bsf_pkg::evt_t rdata
);
  import bsf_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST     = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  evt_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full   = (count_r == FULL_CNT);
  assign rvalid = (count_r != '0);
  assign rdata  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + PW'(1);
    end
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + CW'(1);
      2'b01:   count_nxt = count_r - CW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  `BSF_ASSERT_IMP(a_q_no_overflow, clk, rst_n, push, count_r != FULL_CNT)
  `BSF_ASSERT_IMP(a_q_no_underflow, clk, rst_n, pop, count_r != '0)
  `BSF_ASSERT_NXT(a_q_count_up, clk, rst_n, push && !pop, count_r == $past(count_r) + CW'(1))

endmodule

FILE: rtl/bsf_back.sv
// ----------------------------------------------------------------------------
// BGP session FSM back end
// Session state register, transition decode and registered result stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bgp_session_fsm_core_macros.svh"

module bsf_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  bsf_pkg::evt_t q_rdata,
  output logic          q_pop,
  bsf_out_if.source     out_ch
);
  import bsf_pkg::*;

  state_t session_state_r;
  res_t   res_r, res_nxt;
  logic   out_valid_r;

  assign q_pop = q_valid && (!out_valid_r || out_ch.ready);

  always_comb begin
    res_nxt            = '0;
    res_nxt.next_state = session_state_r;

    unique case (session_state_r)
      ST_IDLE: begin
        res_nxt.retry_timer_action     = TMR_RESTART;
        res_nxt.keepalive_timer_action = TMR_ZERO;
        res_nxt.hold_timer_action      = TMR_ZERO;
        res_nxt.start_connection       = 1'b1;
        res_nxt.next_state             = ST_CONNECT;
      end
      ST_CONNECT: begin
        if (q_rdata.cls != CLS_RETRY) begin
          res_nxt.unexpected_event = 1'b1;
        end else if (q_rdata.conn) begin
          res_nxt.retry_timer_action = TMR_ZERO;
          res_nxt.clear_retry_count  = 1'b1;
          res_nxt.hold_timer_action  = TMR_LARGE;
          res_nxt.finish_init        = 1'b1;
          res_nxt.send_message       = MSG_OPEN;
          res_nxt.next_state         = ST_OPENSENT;
          if (q_rdata.fail) begin
            res_nxt.next_state    = ST_IDLE;
            res_nxt.reset_request = 1'b1;
            res_nxt.reset_reason  = REASON_TCP_FAIL;
          end
        end else begin
          res_nxt.next_state    = ST_IDLE;
          res_nxt.reset_request = 1'b1;
          res_nxt.reset_reason  = REASON_TCP_FAIL;
        end
      end
      ST_OPENSENT: begin
        if (q_rdata.cls == CLS_OPEN) begin
          res_nxt.retry_timer_action     = TMR_ZERO;
          res_nxt.keepalive_timer_action = TMR_RESTART;
          res_nxt.hold_timer_action      = TMR_RESTART;
          res_nxt.send_message           = MSG_KEEPALIVE;
          res_nxt.next_state             = ST_OPENCONFIRM;
          if (q_rdata.fail) begin
            res_nxt.next_state    = ST_IDLE;
            res_nxt.reset_request = 1'b1;
            res_nxt.reset_reason  = REASON_TCP_FAIL;
          end
        end else begin
          if (q_rdata.cls != CLS_OPEN_REJECT) begin
            res_nxt.send_message = MSG_NOTIFY;
            res_nxt.notify_error = q_rdata.note;
          end
          res_nxt.next_state    = ST_IDLE;
          res_nxt.reset_request = 1'b1;
          res_nxt.reset_reason  = q_rdata.reason;
        end
      end
      ST_OPENCONFIRM: begin
        if (q_rdata.cls == CLS_KEEPALIVE) begin
          res_nxt.hold_timer_action = TMR_RESTART;
          res_nxt.next_state        = ST_ESTABLISHED;
        end else if (q_rdata.cls == CLS_KA_TIMER) begin
          res_nxt.keepalive_timer_action = TMR_RESTART;
          res_nxt.send_message           = MSG_KEEPALIVE;
          if (q_rdata.fail) begin
            res_nxt.next_state    = ST_IDLE;
            res_nxt.reset_request = 1'b1;
            res_nxt.reset_reason  = q_rdata.reason;
          end
        end else begin
          if (q_rdata.cls != CLS_NOTIF) begin
            res_nxt.send_message = MSG_NOTIFY;
            res_nxt.notify_error = q_rdata.note;
          end
          res_nxt.next_state    = ST_IDLE;
          res_nxt.reset_request = 1'b1;
          res_nxt.reset_reason  = q_rdata.reason;
        end
      end
      ST_ESTABLISHED: begin
        if (q_rdata.cls == CLS_KEEPALIVE) begin
          res_nxt.hold_timer_action = TMR_RESTART;
        end else if (q_rdata.cls == CLS_UPDATE) begin
          res_nxt.hold_timer_action = TMR_RESTART;
          res_nxt.clear_retry_count = 1'b1;
        end else if (q_rdata.cls == CLS_KA_TIMER) begin
          res_nxt.keepalive_timer_action = TMR_RESTART;
          res_nxt.send_message           = MSG_KEEPALIVE;
          if (q_rdata.fail) begin
            res_nxt.next_state    = ST_IDLE;
            res_nxt.reset_request = 1'b1;
            res_nxt.reset_reason  = REASON_TCP_FAIL;
          end
        end else begin
          if (q_rdata.cls != CLS_NOTIF) begin
            res_nxt.send_message = MSG_NOTIFY;
            res_nxt.notify_error = q_rdata.note_est;
          end
          res_nxt.next_state    = ST_IDLE;
          res_nxt.reset_request = 1'b1;
          res_nxt.reset_reason  = q_rdata.reason;
        end
      end
      default: begin
        // active and unused codes hold
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      session_state_r <= ST_IDLE;
      out_valid_r     <= 1'b0;
    end else begin
      if (q_pop) begin
        session_state_r <= res_nxt.next_state;
        out_valid_r     <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid                  = out_valid_r;
  assign out_ch.next_state             = res_r.next_state;
  assign out_ch.retry_timer_action     = res_r.retry_timer_action;
  assign out_ch.keepalive_timer_action = res_r.keepalive_timer_action;
  assign out_ch.hold_timer_action      = res_r.hold_timer_action;
  assign out_ch.send_message           = res_r.send_message;
  assign out_ch.notify_error           = res_r.notify_error;
  assign out_ch.clear_retry_count      = res_r.clear_retry_count;
  assign out_ch.start_connection       = res_r.start_connection;
  assign out_ch.finish_init            = res_r.finish_init;
  assign out_ch.reset_request          = res_r.reset_request;
  assign out_ch.reset_reason           = res_r.reset_reason;
  assign out_ch.unexpected_event       = res_r.unexpected_event;

  `BSF_ASSERT_IMP(a_state_legal, clk, rst_n, 1'b1, session_state_r <= ST_ESTABLISHED)
  `BSF_ASSERT_IMP(a_reset_to_idle, clk, rst_n, out_valid_r && res_r.reset_request, res_r.next_state == ST_IDLE)
  `BSF_ASSERT_IMP(a_unexp_quiet, clk, rst_n, out_valid_r && res_r.unexpected_event, res_r.next_state == ST_CONNECT && res_r.send_message == MSG_NONE)
  `BSF_ASSERT_NXT(a_pop_shows, clk, rst_n, q_pop, out_valid_r && session_state_r == res_r.next_state)

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// BGP session FSM core - testbench
// Runs a table of directed events through the core, then about 700 random
// events that mostly follow the normal session path. Each action set on the
// result channel is checked field by field against a behavioural model of the
// session or a fixed expectation. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import bsf_pkg::*;

  localparam int RANDOM_EVENTS = 700;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 6;

  localparam ev_t EV_UNKNOWN_14 = 4'd14;
  localparam ev_t EV_UNKNOWN_15 = 4'd15;

  typedef struct packed {
    ev_t  code;
    logic conn;
    logic fail;
    logic fixed;
    res_t exp;
  } stim_row_t;

  localparam res_t EXP_CONNECTING = '{ST_CONNECT, TMR_RESTART, TMR_ZERO, TMR_ZERO,
                                      MSG_NONE, NOTE_NONE, 1'b0, 1'b1, 1'b0, 1'b0,
                                      '0, 1'b0};
  localparam res_t EXP_UNEXPECTED = '{ST_CONNECT, TMR_NONE, TMR_NONE, TMR_NONE,
                                      MSG_NONE, NOTE_NONE, 1'b0, 1'b0, 1'b0, 1'b0,
                                      '0, 1'b1};
  localparam res_t EXP_TCP_FAIL = '{ST_IDLE, TMR_NONE, TMR_NONE, TMR_NONE,
                                    MSG_NONE, NOTE_NONE, 1'b0, 1'b0, 1'b0, 1'b1,
                                    REASON_TCP_FAIL, 1'b0};
  localparam res_t EXP_OPEN_REJECT = '{ST_IDLE, TMR_NONE, TMR_NONE, TMR_NONE,
                                       MSG_NONE, NOTE_NONE, 1'b0, 1'b0, 1'b0, 1'b1,
                                       EV_OPEN_ERR, 1'b0};
  localparam res_t EXP_FSM_NOTE = '{ST_IDLE, TMR_NONE, TMR_NONE, TMR_NONE,
                                    MSG_NOTIFY, NOTE_FSM, 1'b0, 1'b0, 1'b0, 1'b1,
                                    EV_FSM_ERR, 1'b0};
  localparam res_t EXP_UPDATE_NOTE = '{ST_IDLE, TMR_NONE, TMR_NONE, TMR_NONE,
                                       MSG_NOTIFY, NOTE_UPDATE, 1'b0, 1'b0, 1'b0, 1'b1,
                                       EV_UPDATE_ERR, 1'b0};

  // fixed rows carry their own expectation; the rest use the session model
  localparam int N_DIRECTED = 26;
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    '{EV_START,      1'b0, 1'b0, 1'b1, EXP_CONNECTING},
    '{EV_START,      1'b0, 1'b0, 1'b1, EXP_UNEXPECTED},
    '{EV_UNKNOWN_15, 1'b1, 1'b1, 1'b1, EXP_UNEXPECTED},
    '{EV_RETRY,      1'b0, 1'b1, 1'b1, EXP_TCP_FAIL},
    '{EV_UNKNOWN_15, 1'b1, 1'b1, 1'b1, EXP_CONNECTING},
    '{EV_RETRY,      1'b1, 1'b1, 1'b0, '0},
    '{EV_HOLD,       1'b0, 1'b0, 1'b0, '0},
    '{EV_RETRY,      1'b1, 1'b0, 1'b0, '0},
    '{EV_OPEN_ERR,   1'b0, 1'b0, 1'b1, EXP_OPEN_REJECT},
    '{EV_KEEPALIVE,  1'b0, 1'b0, 1'b0, '0},
    '{EV_RETRY,      1'b1, 1'b0, 1'b0, '0},
    '{EV_UNKNOWN_14, 1'b0, 1'b0, 1'b1, EXP_FSM_NOTE},
    '{EV_NOTIF,      1'b0, 1'b0, 1'b0, '0},
    '{EV_RETRY,      1'b1, 1'b0, 1'b0, '0},
    '{EV_OPEN,       1'b0, 1'b1, 1'b0, '0},
    '{EV_UPDATE_ERR, 1'b0, 1'b0, 1'b0, '0},
    '{EV_RETRY,      1'b1, 1'b0, 1'b0, '0},
    '{EV_OPEN,       1'b0, 1'b0, 1'b0, '0},
    '{EV_KA_TIMER,   1'b0, 1'b1, 1'b0, '0},
    '{EV_UNSUP_CAP,  1'b0, 1'b0, 1'b0, '0},
    '{EV_RETRY,      1'b1, 1'b0, 1'b0, '0},
    '{EV_OPEN,       1'b0, 1'b0, 1'b0, '0},
    '{EV_KEEPALIVE,  1'b0, 1'b0, 1'b0, '0},
    '{EV_UPDATE,     1'b0, 1'b0, 1'b0, '0},
    '{EV_KA_TIMER,   1'b0, 1'b0, 1'b0, '0},
    '{EV_UPDATE_ERR, 1'b0, 1'b0, 1'b1, EXP_UPDATE_NOTE}
  };

  logic clk = 1'b0;
  logic rst_n;

  bsf_in_if  in_ch ();
  bsf_out_if out_ch ();

  bgp_session_fsm_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  state_t sess_state;
  res_t   pending_actions[$];
  int     n_mismatch;
  bit     quiet;
  int     idle_cycles;

  function automatic note_t note_for(input ev_t ev, input logic upd_ok);
    if (ev == EV_HEADER_ERR) return NOTE_HEADER;
    if (ev == EV_HOLD) return NOTE_HOLD;
    if (upd_ok && ev == EV_UPDATE_ERR) return NOTE_UPDATE;
    return NOTE_FSM;
  endfunction

  function automatic res_t with_reset(input res_t r, input ev_t reason);
    res_t o;
    o = r;
    o.next_state = ST_IDLE;
    o.reset_request = 1'b1;
    o.reset_reason = reason;
    return o;
  endfunction

  function automatic res_t with_notify(input res_t r, input note_t note, input ev_t ev);
    res_t o;
    o = r;
    o.send_message = MSG_NOTIFY;
    o.notify_error = note;
    return with_reset(o, ev);
  endfunction

  // advances the session state as a side effect
  function automatic res_t predict_actions(input ev_t code, input logic conn,
                                           input logic fail);
    res_t r;
    ev_t  ev;
    ev = (code > EV_FSM_ERR) ? EV_FSM_ERR : code;
    r = '0;
    r.next_state = sess_state;
    case (sess_state)
      ST_IDLE: begin
        r.retry_timer_action = TMR_RESTART;
        r.keepalive_timer_action = TMR_ZERO;
        r.hold_timer_action = TMR_ZERO;
        r.start_connection = 1'b1;
        r.next_state = ST_CONNECT;
      end
      ST_CONNECT: begin
        if (ev != EV_RETRY) begin
          r.unexpected_event = 1'b1;
        end else if (conn) begin
          r.retry_timer_action = TMR_ZERO;
          r.clear_retry_count = 1'b1;
          r.hold_timer_action = TMR_LARGE;
          r.finish_init = 1'b1;
          r.next_state = ST_OPENSENT;
          r.send_message = MSG_OPEN;
          if (fail) r = with_reset(r, REASON_TCP_FAIL);
        end else begin
          r = with_reset(r, REASON_TCP_FAIL);
        end
      end
      ST_OPENSENT: begin
        if (ev == EV_OPEN) begin
          r.retry_timer_action = TMR_ZERO;
          r.keepalive_timer_action = TMR_RESTART;
          r.hold_timer_action = TMR_RESTART;
          r.next_state = ST_OPENCONFIRM;
          r.send_message = MSG_KEEPALIVE;
          if (fail) r = with_reset(r, REASON_TCP_FAIL);
        end else if (ev == EV_OPEN_ERR || ev == EV_UNSUP_CAP) begin
          r = with_reset(r, ev);
        end else begin
          r = with_notify(r, note_for(ev, 1'b0), ev);
        end
      end
      ST_OPENCONFIRM: begin
        if (ev == EV_KEEPALIVE) begin
          r.hold_timer_action = TMR_RESTART;
          r.next_state = ST_ESTABLISHED;
        end else if (ev == EV_KA_TIMER) begin
          r.keepalive_timer_action = TMR_RESTART;
          r.send_message = MSG_KEEPALIVE;
          if (fail) r = with_reset(r, ev);
        end else if (ev == EV_NOTIF || ev == EV_NOTIF_VER) begin
          r = with_reset(r, ev);
        end else begin
          r = with_notify(r, note_for(ev, 1'b0), ev);
        end
      end
      ST_ESTABLISHED: begin
        if (ev == EV_KEEPALIVE) begin
          r.hold_timer_action = TMR_RESTART;
        end else if (ev == EV_UPDATE) begin
          r.hold_timer_action = TMR_RESTART;
          r.clear_retry_count = 1'b1;
        end else if (ev == EV_KA_TIMER) begin
          r.keepalive_timer_action = TMR_RESTART;
          r.send_message = MSG_KEEPALIVE;
          if (fail) r = with_reset(r, REASON_TCP_FAIL);
        end else if (ev == EV_NOTIF || ev == EV_NOTIF_VER) begin
          r = with_reset(r, ev);
        end else begin
          r = with_notify(r, note_for(ev, 1'b1), ev);
        end
      end
      default: ;
    endcase
    sess_state = r.next_state;
    return r;
  endfunction

  // mostly zero, some short, a few long
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp,
                             input logic [31:0] act);
    if (exp !== act) begin
      $error("%s: expected %0d, got %0d", name, exp, act);
      n_mismatch++;
    end
  endtask

  task automatic check_actions(input res_t e);
    check_field("next_state", e.next_state, out_ch.next_state);
    check_field("retry_timer_action", e.retry_timer_action, out_ch.retry_timer_action);
    check_field("keepalive_timer_action", e.keepalive_timer_action,
                out_ch.keepalive_timer_action);
    check_field("hold_timer_action", e.hold_timer_action, out_ch.hold_timer_action);
    check_field("send_message", e.send_message, out_ch.send_message);
    check_field("notify_error", e.notify_error, out_ch.notify_error);
    check_field("clear_retry_count", e.clear_retry_count, out_ch.clear_retry_count);
    check_field("start_connection", e.start_connection, out_ch.start_connection);
    check_field("finish_init", e.finish_init, out_ch.finish_init);
    check_field("reset_request", e.reset_request, out_ch.reset_request);
    check_field("reset_reason", e.reset_reason, out_ch.reset_reason);
    check_field("unexpected_event", e.unexpected_event, out_ch.unexpected_event);
  endtask

  // called at a rising edge; returns at the edge where the transaction is taken
  task automatic send_event(input ev_t code, input logic conn, input logic fail,
                            input logic fixed, input res_t fixed_exp);
    int   gap;
    res_t pred;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pred = predict_actions(code, conn, fail);
    pending_actions.push_back(fixed ? fixed_exp : pred);
    in_ch.valid <= 1'b1;
    in_ch.event_code <= code;
    in_ch.connection_ok <= conn;
    in_ch.send_fails <= fail;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  initial begin
    ev_t  code;
    logic conn;
    logic fail;
    int   r;
    sess_state = ST_IDLE;
    n_mismatch = 0;
    quiet = 1'b0;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.event_code <= '0;
    in_ch.connection_ok <= 1'b0;
    in_ch.send_fails <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++)
      send_event(DIRECTED[i].code, DIRECTED[i].conn, DIRECTED[i].fail,
                 DIRECTED[i].fixed, DIRECTED[i].exp);

    for (int i = 0; i < RANDOM_EVENTS; i++) begin
      quiet = (i % 200) >= 150;
      if (i == 350) begin
        in_ch.valid <= 1'b0;
        while (pending_actions.size() != 0) @(posedge clk);
      end
      code = ev_t'($urandom_range(0, 15));
      conn = 1'($urandom_range(0, 1));
      fail = $urandom_range(0, 15) == 0;
      r = $urandom_range(0, 99);
      case (sess_state)
        ST_CONNECT: if (r < 85) begin
          code = EV_RETRY;
          conn = $urandom_range(0, 9) != 0;
        end
        ST_OPENSENT: if (r < 75) code = EV_OPEN;
        ST_OPENCONFIRM: begin
          if (r < 45) code = EV_KEEPALIVE;
          else if (r < 80) code = EV_KA_TIMER;
        end
        ST_ESTABLISHED: begin
          if (r < 30) code = EV_KEEPALIVE;
          else if (r < 60) code = EV_UPDATE;
          else if (r < 88) code = EV_KA_TIMER;
        end
        default: ;
      endcase
      send_event(code, conn, fail, 1'b0, '0);
    end
    in_ch.valid <= 1'b0;
    quiet = 1'b0;

    while (pending_actions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_mismatch == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  initial begin
    int stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (pending_actions.size() == 0) begin
          $error("next_state: expected no transaction, got %0d", out_ch.next_state);
          n_mismatch++;
        end else begin
          check_actions(pending_actions.pop_front());
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

endmodule
